// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/epdh_pkg.sv =====
// Package of constants and types for the edge point dedup hash core.
package epdh_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int MAX_ENTRIES = 4096;
    localparam int VERTEX_BITS = 24;
    localparam int CFG_W       = 11;
    localparam int FRAC_W      = 17;
    localparam int PID_W       = 12;
    localparam int OUT_V_W     = 24;
    localparam int HASH_W      = 32;
    localparam logic [31:0] HASH_MUL_LOW  = 32'd18457;
    localparam logic [31:0] HASH_MUL_HIGH = 32'd234749;
    localparam logic [16:0] FRAC_ONE      = 17'd65536;
    localparam logic [CFG_W-1:0] BUCKETS_RESET = 11'd1024;

    // Remainder unit control handed from the sequencer.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] rem;
    } t_div_rsp;
endpackage

// ===== hdl/epdh_if.sv =====
// Valid/ready channel interface carrying one item payload.
interface epdh_if #(
    parameter int W = 1
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/epdh_rem.sv =====
// Bit-serial unsigned remainder unit, one quotient bit per cycle.
module epdh_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epdh_pkg::t_div_req i_req,
    output epdh_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_num;
    logic [17:0] r_rem;
    logic [16:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_shift;
    logic [17:0] w_sub;

    assign w_shift = {r_rem[16:0], r_num[31]};
    assign w_sub   = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_sub[17] ? w_shift : w_sub;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[16:0];
endmodule

// ===== hdl/edge_point_dedup_hash_core.sv =====
// Top level of the edge point dedup hash core.
// Items enter on in_ch (vertex_a, vertex_b, edge_fraction) and results leave on out_ch
// (point_id, is_new, table_full, edge_low, edge_high, fraction_out). Both are valid/ready
// channels, and an item moves at a clock edge where valid and ready are high together.
// The user must write the bucket count on cfg_ch only while no item is in flight; the
// block does not enforce it. 0 acts as 1 and values above MAX_BUCKETS act as MAX_BUCKETS.
// One item is worked on at a time with a shared multiplier and a shared bit-serial
// remainder unit. After acceptance it forms the two hash terms in turn, starts the
// remainder, runs the remainder loop, takes the bucket index and then latches the
// bucket head. Each chain entry visited takes a read step and a compare step.
// A miss after L entries needs one more read step, which also writes the new entry
// unless the table is full, and then the output step. A hit on the k-th entry goes
// from its compare step straight to the output step.
// The result waits in its own output register, so the next item can be taken right
// after the output step; no new item is taken before the last one is through. A stalled receiver holds the result,
// and the block stops in its output step until that register is free; nothing is lost.
// After reset a clearing pass sweeps and empties every bucket head, and no item
// is accepted during it. The entry count returns to zero and the bucket count to 1024.
module edge_point_dedup_hash_core #(
    parameter int MAX_BUCKETS = epdh_pkg::MAX_BUCKETS,
    parameter int MAX_ENTRIES = epdh_pkg::MAX_ENTRIES,
    parameter int VERTEX_BITS = epdh_pkg::VERTEX_BITS
) (
    input logic i_clk,
    input logic i_rst_n,
    epdh_if.sink   in_ch,
    epdh_if.source out_ch,
    epdh_if.sink   cfg_ch
);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = EW + 1;
    localparam int VW = VERTEX_BITS;
    localparam int FW = epdh_pkg::FRAC_W;
    localparam int OW = FW + 2 * epdh_pkg::OUT_V_W + 2 + epdh_pkg::PID_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_DIVGO = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_HEAD  = 9'b000100000,
        S_READ  = 9'b001000000,
        S_CMP   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Bucket head memory: valid bit plus entry index, cleared by a sweep.
    logic [EW:0]    r_bmem [MAX_BUCKETS];
    logic [VW-1:0]  r_elo  [MAX_ENTRIES];
    logic [VW-1:0]  r_ehi  [MAX_ENTRIES];
    logic [EW:0]    r_enx  [MAX_ENTRIES];

    logic [epdh_pkg::CFG_W-1:0] r_nb;
    logic [BW:0]    r_clr;
    logic [CW-1:0]  r_cnt;
    logic [VW-1:0]  r_lo, r_hi;
    logic [FW-1:0]  r_frac;
    logic [31:0]    r_prod, r_hash;
    logic           r_neg;
    logic [16:0]    r_n;
    logic [BW-1:0]  r_key;
    logic [EW:0]    r_head, r_cur;
    logic [CW-1:0]  r_steps;
    logic [VW-1:0]  r_rd_lo, r_rd_hi;
    logic [EW:0]    r_rd_nx;
    logic [EW:0]    r_bq;
    logic           r_ovalid, r_new, r_full;
    logic [EW-1:0]  r_pid;
    logic [OW-1:0]  r_odata;
    logic           r_busy_in;

    epdh_pkg::t_div_req w_req;
    epdh_pkg::t_div_rsp w_rsp;
    logic [31:0]    w_mul_a, w_mul_b, w_mul;
    logic [16:0]    w_key;
    logic [VW-1:0]  w_a, w_b;
    logic [FW-1:0]  w_f;
    logic [16:0]    w_n;
    logic           w_take;
    logic           w_match;
    logic           w_walk;
    logic           w_out_free;

    assign w_a = in_ch.data[VW-1:0];
    assign w_b = in_ch.data[VW +: VW];
    assign w_f = (in_ch.data[2*VW +: FW] > epdh_pkg::FRAC_ONE) ? epdh_pkg::FRAC_ONE
                                                                : in_ch.data[2*VW +: FW];
    assign w_n = (r_nb == '0) ? 17'd1 :
                 ({6'd0, r_nb} > 17'(MAX_BUCKETS)) ? 17'(MAX_BUCKETS) : {6'd0, r_nb};

    // One shared multiplier, used for each hash term in turn.
    assign w_mul_a = (r_state == S_IDLE) ? 32'(r_lo) : 32'(r_hi);
    assign w_mul_b = (r_state == S_IDLE) ? epdh_pkg::HASH_MUL_LOW
                                         : epdh_pkg::HASH_MUL_HIGH;
    assign w_mul   = w_mul_a * w_mul_b;

    assign w_req.start    = (r_state == S_DIVGO);
    assign w_req.dividend = r_hash[31] ? (~r_hash + 32'd1) : r_hash;
    assign w_req.divisor  = r_n;

    epdh_rem u_rem (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_key = (r_neg && w_rsp.rem != '0) ? (r_n - w_rsp.rem) : w_rsp.rem;

    assign in_ch.ready  = (r_state == S_IDLE) && !r_busy_in;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    assign w_take     = in_ch.valid && in_ch.ready;
    assign w_match    = (r_rd_lo == r_lo) && (r_rd_hi == r_hi);
    assign w_walk     = r_cur[EW] && (r_steps <= r_cnt);
    assign w_out_free = !r_ovalid || out_ch.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == (BW+1)'(MAX_BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (r_busy_in) n_state = S_MUL;
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (w_rsp.done) n_state = S_HEAD;
            S_HEAD:  n_state = S_READ;
            S_READ:  n_state = w_walk ? S_CMP : S_OUT;
            S_CMP:   n_state = w_match ? S_OUT : S_READ;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_nb      <= epdh_pkg::BUCKETS_RESET;
            r_ovalid  <= 1'b0;
            r_busy_in <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_ch.valid) r_nb <= cfg_ch.data[epdh_pkg::CFG_W-1:0];
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_take) r_busy_in <= 1'b1;
            if (r_state == S_MUL) r_busy_in <= 1'b0;
            // The output register is loaded when it is empty or being emptied.
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
                if (r_new) r_cnt <= r_cnt + 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) r_bmem[r_clr[BW-1:0]] <= '0;
        if (w_take) begin
            if (w_b < w_a) begin
                r_lo <= w_b; r_hi <= w_a; r_frac <= epdh_pkg::FRAC_ONE - w_f;
            end else begin
                r_lo <= w_a; r_hi <= w_b; r_frac <= w_f;
            end
            r_n <= w_n;
        end
        if (r_state == S_IDLE) r_prod <= w_mul;
        if (r_state == S_MUL) r_hash <= r_prod + w_mul;
        if (r_state == S_DIVGO) r_neg <= r_hash[31];
        if (w_rsp.done) r_key <= w_key[BW-1:0];
        // The head is read at the new bucket index as soon as the remainder is done.
        r_bq <= r_bmem[w_rsp.done ? w_key[BW-1:0] : r_key];
        if (r_state == S_HEAD) begin
            r_head  <= r_bq;
            r_cur   <= r_bq;
            r_steps <= '0;
            r_new   <= 1'b0;
            r_full  <= 1'b0;
            r_pid   <= '0;
        end
        if (r_state == S_READ) begin
            r_rd_lo <= r_elo[r_cur[EW-1:0]];
            r_rd_hi <= r_ehi[r_cur[EW-1:0]];
            r_rd_nx <= r_enx[r_cur[EW-1:0]];
            if (!w_walk) begin
                if (r_cnt == CW'(MAX_ENTRIES)) begin
                    r_full <= 1'b1;
                end else begin
                    r_new <= 1'b1;
                    r_pid <= r_cnt[EW-1:0];
                    r_elo[r_cnt[EW-1:0]] <= r_lo;
                    r_ehi[r_cnt[EW-1:0]] <= r_hi;
                    r_enx[r_cnt[EW-1:0]] <= r_head;
                    r_bmem[r_key] <= {1'b1, r_cnt[EW-1:0]};
                end
            end
        end
        if (r_state == S_CMP) begin
            if (w_match) r_pid <= r_cur[EW-1:0];
            r_cur   <= r_rd_nx;
            r_steps <= r_steps + 1'b1;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_odata <= {r_frac, epdh_pkg::OUT_V_W'(r_hi), epdh_pkg::OUT_V_W'(r_lo),
                        r_full, r_new, epdh_pkg::PID_W'(r_pid)};
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready)
    `ASSERT_IMPL(a_new_full_excl, i_clk, i_rst_n, r_ovalid, !(r_new && r_full))
    `ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, r_ovalid)
endmodule

// ===== dv/edge_point_dedup_hash_core_checker.sv =====
// Checker for the edge point dedup hash core: predicts every result and compares it.
`timescale 1ns / 100ps
module edge_point_dedup_hash_core_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    epdh_if      in_mon,
    epdh_if      out_mon,
    epdh_if      cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    typedef struct packed {
        logic [epdh_pkg::FRAC_W-1:0]      fraction;
        logic [epdh_pkg::VERTEX_BITS-1:0] vertex_b;
        logic [epdh_pkg::VERTEX_BITS-1:0] vertex_a;
    } t_edge_item;

    typedef struct packed {
        logic [epdh_pkg::FRAC_W-1:0]  fraction_out;
        logic [epdh_pkg::OUT_V_W-1:0] edge_high;
        logic [epdh_pkg::OUT_V_W-1:0] edge_low;
        logic                         table_full;
        logic                         is_new;
        logic [epdh_pkg::PID_W-1:0]   point_id;
    } t_point_result;

    logic [epdh_pkg::CFG_W-1:0]       bucket_count;
    bit                               head_valid [epdh_pkg::MAX_BUCKETS];
    int                               head_entry [epdh_pkg::MAX_BUCKETS];
    logic [epdh_pkg::VERTEX_BITS-1:0] entry_lo [epdh_pkg::MAX_ENTRIES];
    logic [epdh_pkg::VERTEX_BITS-1:0] entry_hi [epdh_pkg::MAX_ENTRIES];
    bit                               link_valid [epdh_pkg::MAX_ENTRIES];
    int                               link_entry [epdh_pkg::MAX_ENTRIES];
    int                               entries_used;
    t_point_result                    expected_points [$];

    // Finds the edge in the table or inserts it, and returns the point result.
    function automatic t_point_result lookup_or_insert(t_edge_item it);
        t_point_result    r;
        logic [16:0]      f;
        logic [31:0]      h;
        int signed        hs;
        int               n;
        int               key;
        int               cur;
        int               steps;
        bit               have;
        bit               found;
        f = (it.fraction > epdh_pkg::FRAC_ONE) ? epdh_pkg::FRAC_ONE : it.fraction;
        r = '0;
        if (it.vertex_b < it.vertex_a) begin
            r.edge_low     = it.vertex_b;
            r.edge_high    = it.vertex_a;
            r.fraction_out = epdh_pkg::FRAC_ONE - f;
        end else begin
            r.edge_low     = it.vertex_a;
            r.edge_high    = it.vertex_b;
            r.fraction_out = f;
        end
        n = (bucket_count == 0) ? 1 : int'(bucket_count);
        if (n > epdh_pkg::MAX_BUCKETS) n = epdh_pkg::MAX_BUCKETS;
        h = 32'(r.edge_low) * epdh_pkg::HASH_MUL_LOW
            + 32'(r.edge_high) * epdh_pkg::HASH_MUL_HIGH;
        hs = signed'(h);
        key = hs % n;
        if (key < 0) key += n;
        have  = head_valid[key];
        cur   = head_entry[key];
        steps = 0;
        found = 0;
        while (have && cur < epdh_pkg::MAX_ENTRIES && steps <= entries_used && !found) begin
            if (entry_lo[cur] == r.edge_low && entry_hi[cur] == r.edge_high) begin
                found = 1;
                r.point_id = cur[epdh_pkg::PID_W-1:0];
            end else begin
                have = link_valid[cur];
                cur  = link_entry[cur];
                steps++;
            end
        end
        if (!found) begin
            if (entries_used >= epdh_pkg::MAX_ENTRIES) begin
                r.table_full = 1'b1;
            end else begin
                entry_lo[entries_used]   = r.edge_low;
                entry_hi[entries_used]   = r.edge_high;
                link_valid[entries_used] = head_valid[key];
                link_entry[entries_used] = head_entry[key];
                head_valid[key]          = 1;
                head_entry[key]          = entries_used;
                r.point_id               = entries_used[epdh_pkg::PID_W-1:0];
                r.is_new                 = 1'b1;
                entries_used++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point_result want;
        t_point_result got;
        if (!i_rst_n) begin
            bucket_count = epdh_pkg::BUCKETS_RESET;
            for (int i = 0; i < epdh_pkg::MAX_BUCKETS; i++) head_valid[i] = 0;
            entries_used = 0;
            expected_points.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready)
                bucket_count = cfg_mon.data[epdh_pkg::CFG_W-1:0];
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                expected_points.insert(expected_points.size(),
                                       lookup_or_insert(in_mon.data));
            o_pending <= expected_points.size();
        end
    end
endmodule

// ===== dv/edge_point_dedup_hash_core_tb.sv =====
// Testbench top for the edge point dedup hash core: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module edge_point_dedup_hash_core_tb;
    localparam int VB    = epdh_pkg::VERTEX_BITS;
    localparam int FW    = epdh_pkg::FRAC_W;
    localparam int IN_W  = 2 * VB + FW;
    localparam int OUT_W = epdh_pkg::PID_W + 2 + 2 * epdh_pkg::OUT_V_W + FW;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   recv_idle;

    // The most recent edges sent (up to 256), reused so that lookups hit stored entries.
    logic [VB-1:0] seen_lo [$];
    logic [VB-1:0] seen_hi [$];

    epdh_if #(.W(IN_W))  in_ch  (i_clk);
    epdh_if #(.W(OUT_W)) out_ch (i_clk);
    epdh_if #(.W(epdh_pkg::CFG_W)) cfg_ch (i_clk);

    edge_point_dedup_hash_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    edge_point_dedup_hash_core_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .cfg_mon      (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver decides afresh every cycle whether it will take a result.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Offers one item and returns at the edge where it is accepted. Valid is
    // lowered only when an idle gap is chosen, so it never toggles in one step.
    task automatic send_edge(input logic [VB-1:0] va, input logic [VB-1:0] vb,
                             input logic [FW-1:0] frac);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {frac, vb, va};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        seen_lo.insert(seen_lo.size(), va);
        seen_hi.insert(seen_hi.size(), vb);
        if (seen_lo.size() > 256) begin
            void'(seen_lo.pop_front());
            void'(seen_hi.pop_front());
        end
    endtask

    // Stops sending and waits until every result has come back.
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The bucket count is written only while the block is idle.
    task automatic write_buckets(input logic [epdh_pkg::CFG_W-1:0] count);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= count;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [FW-1:0] pick_fraction;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return FW'($urandom_range(131071, 65537));
        if (sel < 15) return '0;
        if (sel < 20) return epdh_pkg::FRAC_ONE;
        return FW'($urandom_range(65536));
    endfunction

    // Most items revisit known edges, in either order, or share small ids so
    // that chains form and lookups hit; the rest are equal ids and wide ids.
    task automatic send_random_edge;
        int sel;
        int k;
        logic [VB-1:0] va;
        logic [VB-1:0] vb;
        sel = $urandom_range(99);
        if (sel < 35 && seen_lo.size() > 0) begin
            k = $urandom_range(seen_lo.size() - 1);
            if ($urandom_range(1)) begin
                va = seen_lo[k];
                vb = seen_hi[k];
            end else begin
                va = seen_hi[k];
                vb = seen_lo[k];
            end
        end else if (sel < 60) begin
            va = VB'($urandom_range(63));
            vb = VB'($urandom_range(63));
        end else if (sel < 70) begin
            va = VB'($urandom);
            vb = va;
        end else begin
            va = VB'($urandom);
            vb = VB'($urandom);
        end
        send_edge(va, vb, pick_fraction());
    endtask

    initial begin
        send_idle = 16;
        recv_idle = 48;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset bucket count: id and fraction extremes,
        // a swap, equal ids, fractions above one and repeats that must match.
        send_edge('0, '0, '0);
        send_edge('0, '1, epdh_pkg::FRAC_ONE);
        send_edge('1, '0, epdh_pkg::FRAC_ONE);
        send_edge('1, '0, '0);
        send_edge('1, '1, 17'h1FFFF);
        send_edge(24'd5, 24'd3, 17'd65537);
        send_edge(24'd3, 24'd5, 17'd1);
        send_edge(24'd7, 24'd7, 17'd12345);
        send_edge(24'hAAAAAA, 24'h555555, 17'h0AAAA);
        send_edge(24'h555555, 24'hAAAAAA, 17'h15555);
        send_edge(24'h800000, 24'h7FFFFF, 17'd32768);

        // A zero count acts as one bucket; old chains stay, so some misses
        // insert duplicates of edges already stored.
        write_buckets('0);
        send_edge(24'd5, 24'd3, 17'd100);
        send_edge(24'd9, 24'd2, 17'd200);
        send_edge(24'd2, 24'd9, 17'd300);
        // A count above the table saturates to the table size.
        write_buckets('1);
        send_edge(24'd9, 24'd2, 17'd400);
        send_edge('0, '1, 17'd500);
        write_buckets(11'd1);
        send_edge(24'd11, 24'd13, 17'd600);
        send_edge(24'd13, 24'd11, 17'd700);

        write_buckets(11'd7);
        repeat (150) send_random_edge();
        write_buckets(11'd1025);
        repeat (250) send_random_edge();

        send_idle = 48;
        recv_idle = 16;
        write_buckets(11'd1023);
        repeat (250) send_random_edge();
        write_buckets(11'd2);
        repeat (100) send_random_edge();

        send_idle = 0;
        recv_idle = 0;
        write_buckets(11'd1024);
        repeat (340) send_random_edge();

        // Mix fresh wide edges with revisits of known ones.
        repeat (40) begin
            if ($urandom_range(1))
                send_edge(VB'($urandom), VB'($urandom), pick_fraction());
            else
                send_random_edge();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
